// ----- src/atc_bp_pkg.sv -----
// ----------------------------------------------------------------------------
// atc_bp_pkg: shared types and constants for the brake pattern block
// Holds the register file layout, the item passed between front and back,
// and the fixed-point constants used by the square root and notch ladder.
// ----------------------------------------------------------------------------
`default_nettype none

package atc_bp_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_STOP_POSITION = 3'd0,
    CFG_DECEL         = 3'd1,
    CFG_MAX_SPEED     = 3'd2,
    CFG_APPROACH_TIME = 3'd3,
    CFG_SERVICE_NOTCH = 3'd4,
    CFG_EMERG_NOTCH   = 3'd5,
    CFG_OVERRIDE      = 3'd6
  } cfg_idx_e;

  // Override codes; the unused code behaves as normal
  typedef enum logic [1:0] {
    OVR_NORMAL    = 2'd0,
    OVR_SERVICE   = 2'd1,
    OVR_EMERGENCY = 2'd2
  } ovr_mode_e;

  typedef struct packed {
    logic [19:0] stop_position_m;
    logic [7:0]  decel_constant;
    logic [8:0]  max_pattern_speed;
    logic [7:0]  approach_time_tenths;
    logic [7:0]  service_max_notch;
    logic [7:0]  emergency_notch;
    logic [1:0]  override_mode;
  } cfg_t;

  localparam int PROD_W = 35;  // remaining cm * decel
  localparam int PROJ_W = 25;  // 10*V + A*t, signed
  localparam int ROOT_W = 9;   // pattern speed width
  localparam int DIST_W = 27;  // 100 * 20-bit meters

  // Any product at or above this has a root beyond the 9-bit range
  localparam logic [PROD_W-1:0] SQRT_SAT_LIM = PROD_W'(100 * (1 << (2 * ROOT_W)));

  localparam int OVER_MARGIN_CENTI = 1000;  // 10 km/h
  localparam int LADDER_STEP       = 400;   // 4.00 km/h per notch, centi
  // floor(x/25) = (x * RECIP25) >> RECIP_SHIFT, exact for x < 43690
  localparam int RECIP25     = 5243;
  localparam int RECIP_SHIFT = 17;

  typedef struct packed {
    logic [PROD_W-1:0] prod;    // remaining distance (cm) times decel
    logic [PROJ_W-1:0] proj;    // projected speed term, two's complement
    logic [15:0]       speed;   // V in 0.01 km/h
  } fe_item_t;

  function automatic logic [PROD_W-1:0] times100(input logic [PROD_W-1:0] x);
    times100 = (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage

`default_nettype wire

// ----- src/atc_bp_front.sv -----
// ----------------------------------------------------------------------------
// atc_bp_front: sample intake
// Two-stage pipeline: remaining distance and projected speed, then the
// distance times decel product handed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_bp_front
  import atc_bp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic [31:0] position_cm_i,
  input  wire logic [15:0] speed_centi_kmh_i,
  input  wire logic [15:0] accel_centi_i,
  output fe_item_t         item_o,
  output logic             item_valid_o,
  input  wire logic        item_ready_i
);

  logic              f1_vld_q, f2_vld_q;
  logic              f1_rdy, f2_rdy;
  logic [DIST_W-1:0] lim_cm;
  logic              beyond;
  logic [DIST_W-1:0] dist_d, dist_q;
  logic [19:0]       v_x10;
  logic signed [PROJ_W-1:0] acc_t;
  logic signed [PROJ_W-1:0] proj_d;
  logic [PROJ_W-1:0] f1_proj_q;
  logic [15:0]       f1_speed_q;
  fe_item_t          f2_item_q;

  assign f2_rdy    = !f2_vld_q || item_ready_i;
  assign f1_rdy    = !f1_vld_q || f2_rdy;
  assign s_ready_o = f1_rdy;

  // stage 1: distance to the stop limit, projected speed
  always_comb begin
    lim_cm = DIST_W'(cfg_i.stop_position_m) * DIST_W'(100);
    beyond = position_cm_i > 32'(lim_cm);
    dist_d = beyond ? '0 : lim_cm - position_cm_i[DIST_W-1:0];
    v_x10  = 20'(speed_centi_kmh_i) * 20'd10;
    acc_t  = PROJ_W'($signed(accel_centi_i)) *
             PROJ_W'($signed({1'b0, cfg_i.approach_time_tenths}));
    proj_d = $signed({5'b0, v_x10}) + acc_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      if (f1_rdy) f1_vld_q <= s_valid_i;
      if (f2_rdy) f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_rdy && s_valid_i) begin
      dist_q     <= dist_d;
      f1_proj_q  <= proj_d;
      f1_speed_q <= speed_centi_kmh_i;
    end
  end

  // stage 2: distance times decel
  always_ff @(posedge clk_i) begin
    if (f2_rdy && f1_vld_q) begin
      f2_item_q.prod  <= PROD_W'(dist_q) * PROD_W'(cfg_i.decel_constant);
      f2_item_q.proj  <= f1_proj_q;
      f2_item_q.speed <= f1_speed_q;
    end
  end

  assign item_o       = f2_item_q;
  assign item_valid_o = f2_vld_q;

endmodule

`default_nettype wire

// ----- src/atc_bp_fifo.sv -----
// ----------------------------------------------------------------------------
// atc_bp_fifo: short queue between front and back
// Register-based, first-word fall-through, full and empty from a count.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_bp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- src/atc_bp_back.sv -----
// ----------------------------------------------------------------------------
// atc_bp_back: pattern speed and brake selection
// Pipelined root (one bit per stage), cap and compare, ladder product,
// reciprocal divide, then notch selection into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_bp_back
  import atc_bp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire fe_item_t item_i,
  input  wire logic  item_valid_i,
  output logic       item_ready_o,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output logic [8:0] pattern_speed_kmh_o,
  output logic [7:0] brake_notch_o,
  output logic       pattern_near_o
);

  localparam int NSQ = ROOT_W;     // root stages
  localparam int SC  = NSQ;        // cap and compare
  localparam int SM  = NSQ + 1;    // ladder product
  localparam int SQ  = NSQ + 2;    // divide by step
  localparam int SO  = NSQ + 3;    // output
  localparam int NST = NSQ + 4;

  typedef struct packed {
    logic near;
    logic below;
    logic over;
    logic vzero;
  } bk_flags_t;

  logic [NST-1:0] vld_q;
  logic [NST:0]   stg_rdy;
  logic [NST-1:0] stg_in_vld;
  logic [NST-1:0] load;

  assign stg_rdy[NST]  = m_ready_i;
  assign stg_in_vld    = {vld_q[NST-2:0], item_valid_i};
  assign item_ready_o  = stg_rdy[0];

  for (genvar i = 0; i < NST; i++) begin : g_ctl
    assign stg_rdy[i] = !vld_q[i] || stg_rdy[i+1];
    assign load[i]    = stg_rdy[i] && stg_in_vld[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (stg_rdy[i]) vld_q[i] <= stg_in_vld[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Root: largest s < 512 with 100*s*s <= prod, one bit per stage
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] rem_q   [NSQ];
  logic [ROOT_W-1:0] root_q  [NSQ];
  logic [PROJ_W-1:0] proj_q  [NSQ];
  logic [15:0]       spd_q   [NSQ];
  logic [NSQ-1:0]    big_q;

  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    localparam int K = NSQ - 1 - j;
    logic [PROD_W-1:0] rem_in, trial;
    logic [ROOT_W-1:0] root_in;
    logic [PROJ_W-1:0] proj_in;
    logic [15:0]       spd_in;
    logic              big_in;

    if (j == 0) begin : g_first
      assign rem_in  = item_i.prod;
      assign root_in = '0;
      assign proj_in = item_i.proj;
      assign spd_in  = item_i.speed;
      assign big_in  = item_i.prod >= SQRT_SAT_LIM;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign proj_in = proj_q[j-1];
      assign spd_in  = spd_q[j-1];
      assign big_in  = big_q[j-1];
    end

    // 100 * ((s+b)^2 - s^2) with b = 2^K
    assign trial = times100((PROD_W'(root_in) << (K + 1)) + (PROD_W'(1) << (2 * K)));

    always_ff @(posedge clk_i) begin
      if (load[j]) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= root_in | (ROOT_W'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
        proj_q[j] <= proj_in;
        spd_q[j]  <= spd_in;
        big_q[j]  <= big_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cap, approach flag, speed versus pattern
  // --------------------------------------------------------------------------
  logic [8:0]        s_cap;
  logic [16:0]       s100;
  logic [PROJ_W-1:0] s1000;
  bk_flags_t         c_fl_d, c_fl_q, m_fl_q, q_fl_q;
  logic [8:0]        c_s_q, m_s_q, q_s_q;
  logic [15:0]       c_diff_q;

  always_comb begin
    if (big_q[NSQ-1] || root_q[NSQ-1] > cfg_i.max_pattern_speed) begin
      s_cap = cfg_i.max_pattern_speed;
    end else begin
      s_cap = root_q[NSQ-1];
    end
    s100         = 17'(s_cap) * 17'd100;
    s1000        = PROJ_W'(s_cap) * PROJ_W'(1000);
    c_fl_d.near  = $signed(proj_q[NSQ-1]) >= $signed(s1000);
    c_fl_d.below = {1'b0, spd_q[NSQ-1]} < s100;
    c_fl_d.over  = 18'(spd_q[NSQ-1]) > 18'(s100) + 18'(OVER_MARGIN_CENTI);
    c_fl_d.vzero = spd_q[NSQ-1] == '0;
  end

  always_ff @(posedge clk_i) begin
    if (load[SC]) begin
      c_s_q    <= s_cap;
      c_fl_q   <= c_fl_d;
      c_diff_q <= spd_q[NSQ-1] - s100[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Ladder: D = (V - 100*S) * floor(E/2)
  // --------------------------------------------------------------------------
  logic [22:0] m_d_q;

  always_ff @(posedge clk_i) begin
    if (load[SM]) begin
      m_s_q  <= c_s_q;
      m_fl_q <= c_fl_q;
      m_d_q  <= 23'(c_diff_q) * 23'(cfg_i.emergency_notch[7:1]);
    end
  end

  // floor(D/400) = floor((D>>4)/25); only used when D < 400*(E-1)
  logic [31:0] qp;
  logic [17:0] ladder_lim;
  logic        ladder_ok;
  logic [7:0]  q_q;
  logic        q_ok_q;

  always_comb begin
    qp         = 32'(m_d_q[22:4]) * 32'(RECIP25);
    ladder_lim = (18'(cfg_i.emergency_notch) - 18'd1) * 18'(LADDER_STEP);
    ladder_ok  = (cfg_i.emergency_notch >= 8'd2) && (m_d_q < 23'(ladder_lim));
  end

  always_ff @(posedge clk_i) begin
    if (load[SQ]) begin
      q_s_q  <= m_s_q;
      q_fl_q <= m_fl_q;
      q_q    <= qp[RECIP_SHIFT +: 8];
      q_ok_q <= ladder_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Notch selection
  // --------------------------------------------------------------------------
  ovr_mode_e  mode;
  logic [7:0] brake_d;
  logic [8:0] o_s_q;
  logic [7:0] o_brake_q;
  logic       o_near_q;

  always_comb begin
    mode = ovr_mode_e'(cfg_i.override_mode);
    if (q_fl_q.over) mode = OVR_EMERGENCY;
    if (q_fl_q.vzero && q_s_q == '0) mode = OVR_SERVICE;
    brake_d = '0;
    if (q_fl_q.near && !q_fl_q.below) begin
      case (mode)
        OVR_SERVICE:   brake_d = cfg_i.service_max_notch;
        OVR_EMERGENCY: brake_d = cfg_i.emergency_notch;
        default: begin
          if (q_fl_q.vzero) brake_d = cfg_i.service_max_notch;
          else if (q_ok_q)  brake_d = q_q + 8'd1;
          else              brake_d = cfg_i.emergency_notch;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[SO]) begin
      o_s_q     <= q_s_q;
      o_brake_q <= brake_d;
      o_near_q  <= q_fl_q.near;
    end
  end

  assign m_valid_o           = vld_q[SO];
  assign pattern_speed_kmh_o = o_s_q;
  assign brake_notch_o       = o_brake_q;
  assign pattern_near_o      = o_near_q;

  a_brake_needs_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SO] && o_brake_q != '0 |-> o_near_q)
    else $error("brake applied without pattern approach");

  a_speed_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SO] |-> o_s_q <= cfg_i.max_pattern_speed)
    else $error("pattern speed above cap");

  a_ladder_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ] && q_ok_q |-> 9'(q_q) + 9'd1 < 9'(cfg_i.emergency_notch))
    else $error("ladder notch out of range");

endmodule

`default_nettype wire

// ----- src/atc_brake_pattern_top.sv -----
// ----------------------------------------------------------------------------
// atc_brake_pattern_top: train-protection brake pattern
// Turns position, speed and acceleration samples into a pattern speed, a
// pattern-approach flag and a brake notch.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel, one sample per item: position
//   in cm, speed in 0.01 km/h, signed acceleration in 0.01 km/h/s. Each item
//   produces exactly one result item on m_axis, in order.
//   Throughput: one item per clock cycle when m_axis_tready stays high.
//   On its way to m_axis_tvalid an item passes 2 front stages (the first
//   loads on the accepting edge), the queue, 9 root stages, 3
//   compare/ladder stages and the output register.
//   The root unit resolves one bit per stage, which sets depth.
//   The front and back are separated by a small queue; a stalled receiver
//   holds the back pipeline, the queue fills, then the front stalls and
//   s_axis_tready drops. No item is dropped or duplicated.
//   Configuration writes (cfg_we_i, cfg_addr_i, cfg_data_i) take effect on
//   the clock edge and must only be issued while no item is in flight.
//   Reset (rst_ni low, asynchronous) empties the pipelines and loads the
//   default register values: stop 225400 m, decel 18, cap 120 km/h,
//   look-ahead 2.5 s, service notch 8, emergency notch 9, normal mode.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_brake_pattern_top
  import atc_bp_pkg::*;
#(
  parameter int FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // cfg
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [19:0] cfg_data_i,
  // sample input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // position_cm, speed_centi_kmh, accel_centi
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // pattern_speed_kmh, brake_notch, pattern_near, 0s
);

  localparam int ItemW = $bits(fe_item_t);

  cfg_t cfg_d, cfg_q;

  // register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_STOP_POSITION: cfg_d.stop_position_m      = cfg_data_i;
        CFG_DECEL:         cfg_d.decel_constant       = cfg_data_i[7:0];
        CFG_MAX_SPEED:     cfg_d.max_pattern_speed    = cfg_data_i[8:0];
        CFG_APPROACH_TIME: cfg_d.approach_time_tenths = cfg_data_i[7:0];
        CFG_SERVICE_NOTCH: cfg_d.service_max_notch    = cfg_data_i[7:0];
        CFG_EMERG_NOTCH:   cfg_d.emergency_notch      = cfg_data_i[7:0];
        CFG_OVERRIDE:      cfg_d.override_mode        = cfg_data_i[1:0];
        default: ;  // writes beyond the map are ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_position_m      <= 20'd225400;
      cfg_q.decel_constant       <= 8'd18;
      cfg_q.max_pattern_speed    <= 9'd120;
      cfg_q.approach_time_tenths <= 8'd25;
      cfg_q.service_max_notch    <= 8'd8;
      cfg_q.emergency_notch      <= 8'd9;
      cfg_q.override_mode        <= OVR_NORMAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front -> queue -> back
  fe_item_t            fe_item, bk_item;
  logic                fe_valid, fe_ready;
  logic                bk_valid, bk_ready;
  logic [ItemW-1:0]    q_data;
  logic [8:0]          pattern_speed_kmh;
  logic [7:0]          brake_notch;
  logic                pattern_near;

  atc_bp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .s_valid_i         (s_axis_tvalid),
    .s_ready_o         (s_axis_tready),
    .position_cm_i     (s_axis_tdata[31:0]),
    .speed_centi_kmh_i (s_axis_tdata[47:32]),
    .accel_centi_i     (s_axis_tdata[63:48]),
    .item_o            (fe_item),
    .item_valid_o      (fe_valid),
    .item_ready_i      (fe_ready)
  );

  atc_bp_fifo #(
    .Width (ItemW),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (q_data)
  );

  assign bk_item = fe_item_t'(q_data);

  atc_bp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .item_i              (bk_item),
    .item_valid_i        (bk_valid),
    .item_ready_o        (bk_ready),
    .m_valid_o           (m_axis_tvalid),
    .m_ready_i           (m_axis_tready),
    .pattern_speed_kmh_o (pattern_speed_kmh),
    .brake_notch_o       (brake_notch),
    .pattern_near_o      (pattern_near)
  );

  assign m_axis_tdata = {6'b0, pattern_near, brake_notch, pattern_speed_kmh};

endmodule

`default_nettype wire

// ----- tb/sv/atc_brake_pattern_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_brake_pattern_top_tb: self-checking bench for the brake pattern block
// Drives position/speed/acceleration samples into s_axis and checks every
// m_axis result against a typed result or an in-bench predictor of the
// pattern speed, approach flag and brake notch. A directed walk covers the
// corner cases first; random phases then vary registers and flow control.
// ----------------------------------------------------------------------------

module atc_brake_pattern_top_tb
  import atc_bp_pkg::*;
();

  localparam int ResetCycles = 8;
  localparam int DrainCycles = 40;   // idle wait after the final drain, past the pipeline depth
  localparam int PhaseItems  = 225;
  localparam int NumPhases   = 8;
  localparam int ReportLimit = 10;

  localparam longint OverMarginCenti = 1000;  // 10 km/h above pattern -> emergency
  localparam longint NotchSpanCenti  = 400;   // 4 km/h per ladder notch

  // Override code 3 has no name in the package; it must behave as normal
  localparam logic [1:0] OvrSpare = 2'd3;

  // Stop point at reset, in cm
  localparam logic [31:0] StopCm = 32'd22540000;

  localparam cfg_t ResetRegs = '{
    stop_position_m: 20'd225400, decel_constant: 8'd18, max_pattern_speed: 9'd120,
    approach_time_tenths: 8'd25, service_max_notch: 8'd8, emergency_notch: 8'd9,
    override_mode: OVR_NORMAL};
  localparam cfg_t MaxRegs = '{
    stop_position_m: 20'hFFFFF, decel_constant: 8'd255, max_pattern_speed: 9'd511,
    approach_time_tenths: 8'd255, service_max_notch: 8'd255, emergency_notch: 8'd255,
    override_mode: OvrSpare};
  localparam cfg_t MinRegs = '{
    stop_position_m: 20'd0, decel_constant: 8'd1, max_pattern_speed: 9'd0,
    approach_time_tenths: 8'd0, service_max_notch: 8'd1, emergency_notch: 8'd2,
    override_mode: OVR_NORMAL};

  // One input item, last field in the low bits
  typedef struct packed {
    logic signed [15:0] accel_centi;
    logic [15:0]        speed_centi_kmh;
    logic [31:0]        position_cm;
  } sample_t;

  // One result item, last field in the low bits
  typedef struct packed {
    logic       pattern_near;
    logic [7:0] brake_notch;
    logic [8:0] pattern_speed_kmh;
  } verdict_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // Directed stimulus row: either a register write or a sample, the latter
  // optionally with a hand-typed result
  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    addr;
    logic [19:0] value;
    sample_t     smp;
    bit          typed;
    verdict_t    want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [19:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // position_cm, speed_centi_kmh, accel_centi
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // pattern_speed_kmh, brake_notch, pattern_near, 0s

  cfg_t        regs_now;       // bench copy of the register file
  verdict_t    verdicts_due[$];
  plan_row_t   plan[$];
  int unsigned err_count      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  atc_brake_pattern_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Pattern speed in km/h: largest s with s*s <= remaining_cm*decel/100,
  // zero past the stop point, then capped.
  function automatic logic [8:0] pattern_of(logic [31:0] pos, cfg_t c);
    longint unsigned lim_cm, quot, root, trial;
    lim_cm = 64'(c.stop_position_m) * 100;
    if (64'(pos) > lim_cm) return 9'd0;
    quot = ((lim_cm - 64'(pos)) * 64'(c.decel_constant)) / 100;
    root = 0;
    // root stays below 2^15 for any 20-bit stop and 8-bit decel
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= quot) root = trial;
    end
    if (root > 64'(c.max_pattern_speed)) root = 64'(c.max_pattern_speed);
    return root[8:0];
  endfunction

  function automatic verdict_t predict_verdict(sample_t smp, cfg_t c);
    verdict_t   r;
    logic [1:0] mode;
    longint     v, a, s, s100, tt, jn, en, notch;
    s    = longint'(pattern_of(smp.position_cm, c));
    v    = longint'(smp.speed_centi_kmh);
    a    = longint'($signed(smp.accel_centi));
    tt   = longint'(c.approach_time_tenths);
    jn   = longint'(c.service_max_notch);
    en   = longint'(c.emergency_notch);
    s100 = 100 * s;
    r.pattern_speed_kmh = s[8:0];
    // projected speed in centi units vs. pattern scaled to match
    r.pattern_near = !(10 * v + a * tt < 1000 * s);
    notch = 0;
    mode  = c.override_mode;
    if (r.pattern_near && v >= s100) begin
      if (v > s100 + OverMarginCenti) mode = OVR_EMERGENCY;
      if (v == 0 && s == 0) mode = OVR_SERVICE;
      if (mode == OVR_SERVICE || (mode != OVR_EMERGENCY && v == 0)) begin
        notch = jn;
      end else if (mode == OVR_EMERGENCY) begin
        notch = en;
      end else begin
        // ladder: first notch whose band covers the overspeed, else E
        notch = (v - s100) * (en / 2) / NotchSpanCenti + 1;
        if (notch > en - 1) notch = en;
      end
    end
    r.brake_notch = notch[7:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random sample source: mostly close to the stop point with speeds around
  // the pattern, so the approach flag and the ladder both get exercised.
  // --------------------------------------------------------------------------
  function automatic sample_t make_sample(cfg_t c);
    sample_t         smp;
    longint unsigned lim_cm, offs;
    int              span, sel;
    longint          spd;
    logic [8:0]      s;
    sel = $urandom_range(0, 99);
    smp.position_cm     = $urandom;
    smp.speed_centi_kmh = 16'($urandom);
    smp.accel_centi     = 16'($urandom);
    if (sel >= 15) begin
      lim_cm = 64'(c.stop_position_m) * 100;
      span   = $urandom_range(0, 27);
      offs   = {$urandom, $urandom} & ((64'd1 << span) - 1);
      if (sel < 22) smp.position_cm = 32'(lim_cm + offs);        // overran the stop
      else if (offs <= lim_cm) smp.position_cm = 32'(lim_cm - offs);
      s   = pattern_of(smp.position_cm, c);
      spd = 100 * longint'(s) + longint'($urandom_range(0, 1800)) - 300;
      if ($urandom_range(0, 7) == 0) spd = 0;
      smp.speed_centi_kmh = (spd < 0) ? 16'd0 : (spd > 65535) ? 16'hFFFF : 16'(spd);
      if ($urandom_range(0, 1) == 0)
        smp.accel_centi = 16'(int'($urandom_range(0, 4000)) - 2000);
    end
    return smp;
  endfunction

  // --------------------------------------------------------------------------
  // Driving helpers (all called at a rising edge)
  // --------------------------------------------------------------------------

  // Single register write; the caller drops cfg_we_i after the last one so
  // back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input cfg_idx_e addr, input logic [19:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= value;
    case (addr)
      CFG_STOP_POSITION: regs_now.stop_position_m      = value;
      CFG_DECEL:         regs_now.decel_constant       = value[7:0];
      CFG_MAX_SPEED:     regs_now.max_pattern_speed    = value[8:0];
      CFG_APPROACH_TIME: regs_now.approach_time_tenths = value[7:0];
      CFG_SERVICE_NOTCH: regs_now.service_max_notch    = value[7:0];
      CFG_EMERG_NOTCH:   regs_now.emergency_notch      = value[7:0];
      CFG_OVERRIDE:      regs_now.override_mode        = value[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(CFG_STOP_POSITION, 20'(c.stop_position_m));
    write_reg(CFG_DECEL,         20'(c.decel_constant));
    write_reg(CFG_MAX_SPEED,     20'(c.max_pattern_speed));
    write_reg(CFG_APPROACH_TIME, 20'(c.approach_time_tenths));
    write_reg(CFG_SERVICE_NOTCH, 20'(c.service_max_notch));
    write_reg(CFG_EMERG_NOTCH,   20'(c.emergency_notch));
    write_reg(CFG_OVERRIDE,      20'(c.override_mode));
  endtask

  // Present one item, with random idle cycles ahead of it, and hold it until
  // the block takes it. tvalid stays high afterwards for a back-to-back item.
  task automatic send_sample(input sample_t smp, input bit typed, input verdict_t want);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdicts_due.insert(verdicts_due.size(), typed ? want : predict_verdict(smp, regs_now));
  endtask

  // Block goes idle once every result is back; each item yields one result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_sample(input logic [31:0] pos, input logic [15:0] spd,
                            input logic [15:0] acc);
    plan_row_t row;
    row.kind  = ROW_SAMPLE;
    row.addr  = CFG_STOP_POSITION;
    row.value = '0;
    row.smp   = '{accel_centi: acc, speed_centi_kmh: spd, position_cm: pos};
    row.typed = 1'b0;
    row.want  = '0;
    plan.insert(plan.size(), row);
  endtask

  task automatic add_checked(input logic [31:0] pos, input logic [15:0] spd,
                             input logic [15:0] acc, input logic [8:0] pat,
                             input logic [7:0] notch, input logic near);
    add_sample(pos, spd, acc);
    plan[$].typed = 1'b1;
    plan[$].want  = '{pattern_near: near, brake_notch: notch, pattern_speed_kmh: pat};
  endtask

  task automatic add_write(input cfg_idx_e addr, input logic [19:0] value);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.addr  = addr;
    row.value = value;
    row.smp   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan.insert(plan.size(), row);
  endtask

  task automatic log_mismatch(input string what, input int unsigned want,
                              input int unsigned got);
    err_count++;
    if (err_count <= ReportLimit)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls; every accepted result is checked in order
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[17:0];
      if (verdicts_due.size() == 0) begin
        log_mismatch("unexpected result, pattern_speed_kmh", 0, got.pattern_speed_kmh);
      end else begin
        want = verdicts_due.pop_front();
        if (got.pattern_speed_kmh !== want.pattern_speed_kmh)
          log_mismatch("pattern_speed_kmh", want.pattern_speed_kmh, got.pattern_speed_kmh);
        if (got.brake_notch !== want.brake_notch)
          log_mismatch("brake_notch", want.brake_notch, got.brake_notch);
        if (got.pattern_near !== want.pattern_near)
          log_mismatch("pattern_near", want.pattern_near, got.pattern_near);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cfg_t next_regs;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    regs_now      = ResetRegs;

    // Directed walk. Typed results are the ones obvious from the rules:
    // cap far from the stop, standstill past the stop, gross overspeed.
    add_checked(32'd0, 16'd0, 16'd0, 9'd120, 8'd0, 1'b0);
    add_checked(32'hFFFFFFFF, 16'd0, 16'd0, 9'd0, 8'd8, 1'b1);        // past stop, stopped
    add_checked(32'hFFFFFFFF, 16'hFFFF, 16'h7FFF, 9'd0, 8'd9, 1'b1);
    add_checked(32'd0, 16'hFFFF, 16'h8000, 9'd120, 8'd0, 1'b0);      // hard decel: not near
    add_checked(32'd0, 16'hFFFF, 16'h7FFF, 9'd120, 8'd9, 1'b1);
    add_checked(StopCm, 16'd0, 16'd0, 9'd0, 8'd8, 1'b1);             // exactly at the stop
    // 1 m before the stop: pattern is 4 km/h
    add_sample(StopCm - 100, 16'd400, 16'd0);                         // on pattern: first notch
    add_sample(StopCm - 100, 16'd1400, 16'd0);                        // margin edge, ladder
    add_sample(StopCm - 100, 16'd1401, 16'd0);                        // just past margin
    add_sample(StopCm - 100, 16'd399, 16'd1);                         // near, below pattern
    add_sample(StopCm - 100, 16'd1000, 16'd0);
    add_write(CFG_OVERRIDE, 20'(OVR_SERVICE));
    add_sample(StopCm - 100, 16'd500, 16'd0);
    add_write(CFG_OVERRIDE, 20'(OVR_EMERGENCY));
    add_sample(StopCm - 100, 16'd500, 16'd0);
    add_write(CFG_OVERRIDE, 20'(OvrSpare));                           // spare code acts normal
    add_sample(StopCm - 100, 16'd500, 16'd0);
    // emergency notch too small for a ladder
    add_write(CFG_OVERRIDE, 20'(OVR_NORMAL));
    add_write(CFG_EMERG_NOTCH, 20'd1);
    add_sample(StopCm - 100, 16'd500, 16'd0);
    add_write(CFG_EMERG_NOTCH, 20'd0);
    add_sample(StopCm - 100, 16'd500, 16'd0);
    add_write(CFG_DECEL, 20'd0);                                      // no braking room
    add_checked(32'd0, 16'd0, 16'd0, 9'd0, 8'd8, 1'b1);
    // all registers but the override at their top
    add_write(CFG_STOP_POSITION, 20'hFFFFF);
    add_write(CFG_DECEL, 20'd255);
    add_write(CFG_MAX_SPEED, 20'd511);
    add_write(CFG_APPROACH_TIME, 20'd255);
    add_write(CFG_SERVICE_NOTCH, 20'd255);
    add_write(CFG_EMERG_NOTCH, 20'd255);
    add_checked(32'd0, 16'hFFFF, 16'h7FFF, 9'd511, 8'd255, 1'b1);
    add_checked(32'd0, 16'd0, 16'd0, 9'd511, 8'd0, 1'b0);
    // all registers at their floor
    add_write(CFG_STOP_POSITION, 20'd0);
    add_write(CFG_DECEL, 20'd1);
    add_write(CFG_MAX_SPEED, 20'd0);
    add_write(CFG_APPROACH_TIME, 20'd0);
    add_write(CFG_SERVICE_NOTCH, 20'd1);
    add_write(CFG_EMERG_NOTCH, 20'd2);
    add_checked(32'd0, 16'd0, 16'd0, 9'd0, 8'd1, 1'b1);
    add_checked(32'd1, 16'hFFFF, 16'h8000, 9'd0, 8'd2, 1'b1);
    add_sample(32'd0, 16'd300, 16'd0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[k].addr, plan[k].value);
      end else begin
        cfg_we_i <= 1'b0;
        send_sample(plan[k].smp, plan[k].typed, plan[k].want);
      end
    end

    // Random phases: flow control cycles through none / sender gaps /
    // receiver stalls / both; registers reset, random, or at an extreme.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 0) begin
        next_regs = ResetRegs;
      end else if (ph == 4) begin
        next_regs = MaxRegs;
      end else if (ph == 7) begin
        next_regs = MinRegs;
      end else begin
        next_regs.stop_position_m      = 20'($urandom_range(0, 20'hFFFFF));
        next_regs.decel_constant       = 8'($urandom_range(1, 255));
        next_regs.max_pattern_speed    = 9'($urandom_range(0, 511));
        next_regs.approach_time_tenths = 8'($urandom_range(0, 255));
        next_regs.service_max_notch    = 8'($urandom_range(1, 255));
        next_regs.emergency_notch      = 8'($urandom_range(2, 255));
        next_regs.override_mode        = 2'($urandom_range(0, 3));
      end
      write_all(next_regs);
      cfg_we_i <= 1'b0;
      repeat (PhaseItems) send_sample(make_sample(regs_now), 1'b0, '0);
    end

    drain();
    // extra cycles to catch any stray result after the last one
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && verdicts_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/atc_bp_pkg.sv
src/atc_bp_front.sv
src/atc_bp_fifo.sv
src/atc_bp_back.sv
src/atc_brake_pattern_top.sv
tb/sv/atc_brake_pattern_top_tb.sv
